FILE: hdl/dmt_pkg.sv
`timescale 1ns / 1ps

package dmt_pkg;

  localparam int SHIFT_WIDTH = 17;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int STATUS_W    = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_RE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_IM = 2'd1;

  localparam logic OP_POINT  = 1'b0;
  localparam logic OP_CIRCLE = 1'b1;

  localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_ZERO_DEN = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_SAT      = 2'd2;

endpackage

FILE: hdl/dmt_if.sv
`timescale 1ns / 1ps

interface dmt_in_if #(
  parameter int COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic signed [COORD_WIDTH-1:0] in_x;
  logic signed [COORD_WIDTH-1:0] in_y;

  modport source (output valid, operation, in_x, in_y, input ready);
  modport sink (input valid, operation, in_x, in_y, output ready);
endinterface

interface dmt_out_if #(
  parameter int COORD_WIDTH = 32
);
  import dmt_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] out_x;
  logic signed [COORD_WIDTH-1:0] out_y;
  logic [STATUS_W-1:0]           status;

  modport source (output valid, out_x, out_y, status, input ready);
  modport sink (input valid, out_x, out_y, status, output ready);
endinterface

interface dmt_cfg_if;
  import dmt_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/disk_mobius_transform_core.sv
`timescale 1ns / 1ps
// Disk Mobius transform core.
// Input channel in_i: one complex Q value (in_x, in_y) and an operation bit;
// OP_POINT maps a point z to (z-c)/(1-z*conj(c)), OP_CIRCLE maps a geodesic
// circle centre. The shift c comes from the two registers on cfg_i
// (index 0 real part, index 1 imaginary part); write them only while idle.
// Output channel out_o: out_x, out_y and status (ok, zero divisor, saturated).
// An input transfer passes, in order, through six arithmetic stages, one
// overflow-check stage, one restoring divider stage per quotient bit
// (COORD_WIDTH + 1 of them, both parts in parallel) and the output register
// before its result shows on out_o. Throughput is one item per cycle while
// out_o.ready does not hold the pipeline; the divider stages set the latency.
// The whole pipeline advances together; when the receiver holds out_o.ready
// low with a result waiting, every stage holds and in_i.ready drops, so
// nothing is lost or repeated. in_i.ready is high whenever the output
// register is empty or being taken.
// Reset clears all valid bits and both shift registers to zero; cfg_i is
// always ready.
module disk_mobius_transform_core #(
  parameter int FRAC_BITS   = 16,
  parameter int COORD_WIDTH = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  dmt_in_if.sink   in_i,
  dmt_out_if.source out_o,
  dmt_cfg_if.sink  cfg_i
);
  import dmt_pkg::*;

  localparam int SW    = SHIFT_WIDTH;
  localparam int W     = COORD_WIDTH;
  localparam int F     = FRAC_BITS;
  localparam int PW    = W + SW;
  localparam int RDW   = PW + 1;
  localparam int OW    = 2 * F + 2;
  localparam int DRW   = ((RDW > OW) ? RDW : OW) + 1;
  localparam int DL    = (DRW + 1) / 2;
  localparam int DH    = DRW - DL;
  localparam int NRW   = ((W > SW) ? W : SW) + 1;
  localparam int CRW   = 2 * SW;
  localparam int CCW   = CRW + 1;
  localparam int CL    = (CCW + 1) / 2;
  localparam int CH    = CCW - CL;
  localparam int LW    = ((W > SW + 1) ? W : SW + 1) + 2;
  localparam int XCW   = W + CCW;
  localparam int DCW   = ((OW > RDW) ? OW : RDW) + 3;
  localparam int PD    = 2 * DL + 2;
  localparam int PN    = NRW + DL + 1;
  localparam int PC    = W + CL + 1;
  localparam int DSQW  = 2 * DRW + 1;
  localparam int NPW   = NRW + DRW + 1;
  localparam int XPW   = XCW + 1;
  localparam int DENPW = 2 * DRW + 2;
  localparam int NUMPW = NRW + DRW + 2 + 2 * F;
  localparam int MW    = ((LW + 2 * F > XCW) ? LW + 2 * F : XCW) + 2;
  localparam int NW1   = (NUMPW > MW) ? NUMPW : MW;
  localparam int NW2   = (DENPW > DCW) ? DENPW : DCW;
  localparam int NW    = ((NW1 > NW2) ? NW1 : NW2) + 1;
  localparam int QW    = W + 1;
  localparam int EW    = NW + QW;

  localparam logic signed [OW-1:0] ONE_C = OW'(1) << (2 * F);
  localparam logic [QW-1:0] HALF_C = QW'(1) << (W - 1);
  localparam logic [W-1:0]  MAX_C  = {1'b0, {(W - 1){1'b1}}};
  localparam logic [W-1:0]  MIN_C  = {1'b1, {(W - 1){1'b0}}};

  typedef struct packed {
    logic [NW-1:0] rr;
    logic [NW-1:0] ri;
    logic [NW-1:0] dv;
    logic [QW-1:0] qr;
    logic [QW-1:0] qi;
    logic          ngr;
    logic          ngi;
    logic          ovr;
    logic          ovi;
    logic          zero;
  } div_t;

  // configuration
  logic signed [SW-1:0] shift_re_q, shift_im_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_re_q <= '0;
      shift_im_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_SHIFT_RE: shift_re_q <= cfg_i.data[SW-1:0];
        REG_SHIFT_IM: shift_im_q <= cfg_i.data[SW-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic adv;
  logic out_valid_q;
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic [QW:0] vld_q;

  assign adv        = !out_valid_q || out_o.ready;
  assign in_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      v6_q        <= 1'b0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= in_i.valid;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      v5_q        <= v4_q;
      v6_q        <= v5_q;
      vld_q       <= {vld_q[QW-1:0], v6_q};
      out_valid_q <= vld_q[QW];
    end
  end

  // stage 1: narrow products
  logic                  op1_q;
  logic signed [W-1:0]   x1_q, y1_q;
  logic signed [PW-1:0]  xcr1_q, yci1_q, xci1_q, ycr1_q;
  logic signed [CRW-1:0] crr1_q, cii1_q, cri1_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      op1_q  <= in_i.operation;
      x1_q   <= in_i.in_x;
      y1_q   <= in_i.in_y;
      xcr1_q <= PW'(in_i.in_x) * PW'(shift_re_q);
      yci1_q <= PW'(in_i.in_y) * PW'(shift_im_q);
      xci1_q <= PW'(in_i.in_x) * PW'(shift_im_q);
      ycr1_q <= PW'(in_i.in_y) * PW'(shift_re_q);
      crr1_q <= CRW'(shift_re_q) * CRW'(shift_re_q);
      cii1_q <= CRW'(shift_im_q) * CRW'(shift_im_q);
      cri1_q <= CRW'(shift_re_q) * CRW'(shift_im_q);
    end
  end

  // stage 2: sums feeding the wide products
  logic                  op2_q;
  logic signed [W-1:0]   x2_q, y2_q;
  logic signed [RDW-1:0] rdot_d, di2_q;
  logic signed [DRW-1:0] dr2_q;
  logic signed [NRW-1:0] nr2_q, ni2_q;
  logic signed [CCW-1:0] c2r2_q, c2i2_q;
  logic signed [LW-1:0]  lr2_q, li2_q;
  logic signed [DCW-1:0] dc2_q;

  assign rdot_d = RDW'(xcr1_q) + RDW'(yci1_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      op2_q  <= op1_q;
      x2_q   <= x1_q;
      y2_q   <= y1_q;
      di2_q  <= RDW'(xci1_q) - RDW'(ycr1_q);
      dr2_q  <= DRW'(ONE_C) - DRW'(rdot_d);
      nr2_q  <= NRW'(x1_q) - NRW'(shift_re_q);
      ni2_q  <= NRW'(y1_q) - NRW'(shift_im_q);
      c2r2_q <= CCW'(crr1_q) - CCW'(cii1_q);
      c2i2_q <= CCW'(cri1_q) <<< 1;
      lr2_q  <= LW'(x1_q) - (LW'(shift_re_q) <<< 1);
      li2_q  <= LW'(y1_q) - (LW'(shift_im_q) <<< 1);
      dc2_q  <= DCW'(ONE_C) + DCW'(crr1_q) + DCW'(cii1_q) - (DCW'(rdot_d) <<< 1);
    end
  end

  // stage 3: partial products of the wide multiplies
  logic signed [DH-1:0]   drh;
  logic signed [DL:0]     drl;
  logic signed [CH-1:0]   c2rh, c2ih;
  logic signed [CL:0]     c2rl, c2il;
  logic                   op3_q;
  logic signed [LW-1:0]   lr3_q, li3_q;
  logic signed [DCW-1:0]  dc3_q;
  logic signed [PD-1:0]   drhh3_q, drhl3_q, drll3_q, dihh3_q, dihl3_q, dill3_q;
  logic signed [PN-1:0]   nrdh3_q, nrdl3_q, nidh3_q, nidl3_q;
  logic signed [PN-1:0]   nrih3_q, nril3_q, niih3_q, niil3_q;
  logic signed [PC-1:0]   xrh3_q, xrl3_q, yrh3_q, yrl3_q;
  logic signed [PC-1:0]   xih3_q, xil3_q, yih3_q, yil3_q;

  assign drh  = $signed(dr2_q[DRW-1:DL]);
  assign drl  = $signed({1'b0, dr2_q[DL-1:0]});
  assign c2rh = $signed(c2r2_q[CCW-1:CL]);
  assign c2rl = $signed({1'b0, c2r2_q[CL-1:0]});
  assign c2ih = $signed(c2i2_q[CCW-1:CL]);
  assign c2il = $signed({1'b0, c2i2_q[CL-1:0]});

  // di is split on the same boundary as dr after widening to DRW bits
  logic signed [DRW-1:0] diw;
  logic signed [DH-1:0]  dih_w;
  logic signed [DL:0]    dil_w;
  assign diw   = DRW'(di2_q);
  assign dih_w = $signed(diw[DRW-1:DL]);
  assign dil_w = $signed({1'b0, diw[DL-1:0]});

  always_ff @(posedge clk_i) begin
    if (adv) begin
      op3_q   <= op2_q;
      lr3_q   <= lr2_q;
      li3_q   <= li2_q;
      dc3_q   <= dc2_q;
      drhh3_q <= PD'(drh) * PD'(drh);
      drhl3_q <= PD'(drh) * PD'(drl);
      drll3_q <= PD'(drl) * PD'(drl);
      dihh3_q <= PD'(dih_w) * PD'(dih_w);
      dihl3_q <= PD'(dih_w) * PD'(dil_w);
      dill3_q <= PD'(dil_w) * PD'(dil_w);
      nrdh3_q <= PN'(nr2_q) * PN'(drh);
      nrdl3_q <= PN'(nr2_q) * PN'(drl);
      nidh3_q <= PN'(ni2_q) * PN'(drh);
      nidl3_q <= PN'(ni2_q) * PN'(drl);
      nrih3_q <= PN'(nr2_q) * PN'(dih_w);
      nril3_q <= PN'(nr2_q) * PN'(dil_w);
      niih3_q <= PN'(ni2_q) * PN'(dih_w);
      niil3_q <= PN'(ni2_q) * PN'(dil_w);
      xrh3_q  <= PC'(x2_q) * PC'(c2rh);
      xrl3_q  <= PC'(x2_q) * PC'(c2rl);
      yrh3_q  <= PC'(y2_q) * PC'(c2rh);
      yrl3_q  <= PC'(y2_q) * PC'(c2rl);
      xih3_q  <= PC'(x2_q) * PC'(c2ih);
      xil3_q  <= PC'(x2_q) * PC'(c2il);
      yih3_q  <= PC'(y2_q) * PC'(c2ih);
      yil3_q  <= PC'(y2_q) * PC'(c2il);
    end
  end

  // stage 4: assemble the wide products
  logic                   op4_q;
  logic signed [LW-1:0]   lr4_q, li4_q;
  logic signed [DCW-1:0]  dc4_q;
  logic signed [DSQW-1:0] drsq4_q, disq4_q;
  logic signed [NPW-1:0]  nrdr4_q, nidr4_q, nrdi4_q, nidi4_q;
  logic signed [XPW-1:0]  xc2r4_q, yc2r4_q, xc2i4_q, yc2i4_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      op4_q   <= op3_q;
      lr4_q   <= lr3_q;
      li4_q   <= li3_q;
      dc4_q   <= dc3_q;
      drsq4_q <= (DSQW'(drhh3_q) <<< (2 * DL)) + (DSQW'(drhl3_q) <<< (DL + 1))
                 + DSQW'(drll3_q);
      disq4_q <= (DSQW'(dihh3_q) <<< (2 * DL)) + (DSQW'(dihl3_q) <<< (DL + 1))
                 + DSQW'(dill3_q);
      nrdr4_q <= (NPW'(nrdh3_q) <<< DL) + NPW'(nrdl3_q);
      nidr4_q <= (NPW'(nidh3_q) <<< DL) + NPW'(nidl3_q);
      nrdi4_q <= (NPW'(nrih3_q) <<< DL) + NPW'(nril3_q);
      nidi4_q <= (NPW'(niih3_q) <<< DL) + NPW'(niil3_q);
      xc2r4_q <= (XPW'(xrh3_q) <<< CL) + XPW'(xrl3_q);
      yc2r4_q <= (XPW'(yrh3_q) <<< CL) + XPW'(yrl3_q);
      xc2i4_q <= (XPW'(xih3_q) <<< CL) + XPW'(xil3_q);
      yc2i4_q <= (XPW'(yih3_q) <<< CL) + XPW'(yil3_q);
    end
  end

  // stage 5: numerators and divisor, pick by operation
  logic signed [DENPW-1:0] denp;
  logic signed [NUMPW-1:0] numrp, numip;
  logic signed [MW-1:0]    mr, mi;
  logic signed [NW-1:0]    numr5_q, numi5_q, den5_q;

  assign denp  = DENPW'(drsq4_q) + DENPW'(disq4_q);
  assign numrp = (NUMPW'(nrdr4_q) + NUMPW'(nidi4_q)) <<< (2 * F);
  assign numip = (NUMPW'(nidr4_q) - NUMPW'(nrdi4_q)) <<< (2 * F);
  assign mr    = (MW'(lr4_q) <<< (2 * F)) + MW'(xc2r4_q) + MW'(yc2i4_q);
  assign mi    = (MW'(li4_q) <<< (2 * F)) + MW'(xc2i4_q) - MW'(yc2r4_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (op4_q == OP_CIRCLE) begin
        numr5_q <= NW'(mr);
        numi5_q <= NW'(mi);
        den5_q  <= NW'(dc4_q);
      end else begin
        numr5_q <= NW'(numrp);
        numi5_q <= NW'(numip);
        den5_q  <= NW'(denp);
      end
    end
  end

  // stage 6: magnitudes and quotient signs
  logic [NW-1:0] magr6_q, magi6_q, magd6_q;
  logic          ngr6_q, ngi6_q, zero6_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      magr6_q <= numr5_q[NW-1] ? $unsigned(-numr5_q) : $unsigned(numr5_q);
      magi6_q <= numi5_q[NW-1] ? $unsigned(-numi5_q) : $unsigned(numi5_q);
      magd6_q <= den5_q[NW-1] ? $unsigned(-den5_q) : $unsigned(den5_q);
      ngr6_q  <= numr5_q[NW-1] ^ den5_q[NW-1];
      ngi6_q  <= numi5_q[NW-1] ^ den5_q[NW-1];
      zero6_q <= (den5_q == '0);
    end
  end

  // divider: entry stage flags quotients too wide for QW bits
  div_t dv_q [QW+1];
  logic [EW-1:0] dlim;

  assign dlim = EW'(magd6_q) << QW;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_q[0].rr   <= magr6_q;
      dv_q[0].ri   <= magi6_q;
      dv_q[0].dv   <= magd6_q;
      dv_q[0].qr   <= '0;
      dv_q[0].qi   <= '0;
      dv_q[0].ngr  <= ngr6_q;
      dv_q[0].ngi  <= ngi6_q;
      dv_q[0].ovr  <= (EW'(magr6_q) >= dlim);
      dv_q[0].ovi  <= (EW'(magi6_q) >= dlim);
      dv_q[0].zero <= zero6_q;
    end
  end

  // one restoring step per stage, most significant quotient bit first
  for (genvar k = 1; k <= QW; k++) begin : g_div
    localparam int BIT = QW - k;
    logic [EW-1:0] sh, rre, rie;
    div_t          nxt;

    always_comb begin
      nxt = dv_q[k-1];
      sh  = EW'(dv_q[k-1].dv) << BIT;
      rre = EW'(dv_q[k-1].rr);
      rie = EW'(dv_q[k-1].ri);
      if (rre >= sh) begin
        nxt.rr      = NW'(rre - sh);
        nxt.qr[BIT] = 1'b1;
      end
      if (rie >= sh) begin
        nxt.ri      = NW'(rie - sh);
        nxt.qi[BIT] = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_q[k] <= nxt;
      end
    end
  end

  // output: sign, clamp, status
  function automatic logic [W:0] clamp_part(logic [QW-1:0] mag, logic neg, logic ov);
    logic [W:0] res;
    res = {1'b0, mag[W-1:0]};
    if (ov) begin
      res = {1'b1, (neg ? MIN_C : MAX_C)};
    end else if (neg) begin
      if (mag > HALF_C) begin
        res = {1'b1, MIN_C};
      end else begin
        res = {1'b0, W'(-mag)};
      end
    end else if (mag >= HALF_C) begin
      res = {1'b1, MAX_C};
    end
    return res;
  endfunction

  logic [W:0]          cx, cy;
  logic [W-1:0]        out_x_q, out_y_q;
  logic [STATUS_W-1:0] status_q;

  assign cx = clamp_part(dv_q[QW].qr, dv_q[QW].ngr, dv_q[QW].ovr);
  assign cy = clamp_part(dv_q[QW].qi, dv_q[QW].ngi, dv_q[QW].ovi);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (dv_q[QW].zero) begin
        out_x_q  <= '0;
        out_y_q  <= '0;
        status_q <= STAT_ZERO_DEN;
      end else begin
        out_x_q  <= cx[W-1:0];
        out_y_q  <= cy[W-1:0];
        status_q <= (cx[W] || cy[W]) ? STAT_SAT : STAT_OK;
      end
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.out_x  = out_x_q;
  assign out_o.out_y  = out_y_q;
  assign out_o.status = status_q;

  // checks
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable({v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, vld_q}))
    else $error("pipeline valid bits moved during a stall");

  a_zero_outputs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q == STAT_ZERO_DEN |-> out_x_q == '0 && out_y_q == '0)
    else $error("zero divisor result is not zero");

  a_sat_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q == STAT_SAT |->
      out_x_q == MAX_C || out_x_q == MIN_C || out_y_q == MAX_C || out_y_q == MIN_C)
    else $error("saturated result not at a range limit");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> status_q == STAT_OK || status_q == STAT_ZERO_DEN
                    || status_q == STAT_SAT)
    else $error("undefined status code");

  a_ready_follows_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |=> out_valid_q)
    else $error("stalled result dropped");

endmodule
